/* design/nfos_pkg.sv */
// Package for the NAND flash operation sequencer.
// Request, bus kind, phase and burst types plus ONFI command bytes.
// No dependencies.
`default_nettype none

package nfos_pkg;

    typedef enum logic [2:0] {
        REQ_START_READ  = 3'd0,
        REQ_START_PROG  = 3'd1,
        REQ_START_ERASE = 3'd2,
        REQ_DATA_BYTE   = 3'd3,
        REQ_CONFIRM     = 3'd4,
        REQ_BUSY_DONE   = 3'd5,
        REQ_READ_STROBE = 3'd6,
        REQ_TICK        = 3'd7
    } req_t;

    typedef enum logic [2:0] {
        BUS_COMMAND    = 3'd0,
        BUS_ADDRESS    = 3'd1,
        BUS_WRITE_DATA = 3'd2,
        BUS_READ_DATA  = 3'd3,
        BUS_COMPLETION = 3'd4,
        BUS_SEQ_ERROR  = 3'd5
    } bus_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOAD = 2'd1,
        PH_BUSY = 2'd2,
        PH_OUT  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_PROG  = 2'd1,
        OP_ERASE = 2'd2
    } op_kind_t;

    // what a buffered request expands into on the output side
    typedef enum logic [3:0] {
        BK_READ        = 4'd0,
        BK_PROG        = 4'd1,
        BK_ERASE       = 4'd2,
        BK_DATA        = 4'd3,
        BK_CONFIRM     = 4'd4,
        BK_DONE_READ   = 4'd5,
        BK_DONE_STATUS = 4'd6,
        BK_STROBE      = 4'd7,
        BK_ABORT       = 4'd8,
        BK_ERROR       = 4'd9
    } burst_kind_t;

    typedef enum logic [1:0] {
        CFG_ABORT_TICKS   = 2'd0,
        CFG_FAIL_MASK     = 2'd1,
        CFG_RESET_COMMAND = 2'd2
    } cfg_reg_t;

    localparam logic [7:0] CMD_READ         = 8'h00;
    localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;
    localparam logic [7:0] CMD_PROGRAM      = 8'h80;
    localparam logic [7:0] CMD_PROG_CONFIRM = 8'h10;
    localparam logic [7:0] CMD_ERASE        = 8'h60;
    localparam logic [7:0] CMD_ERASE_CONFIRM = 8'hD0;
    localparam logic [7:0] CMD_STATUS_POLL  = 8'h70;

    localparam logic [31:0] TICKS_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

/* design/nand_flash_op_sequencer.sv */
// NAND flash operation sequencer: turns requests into NAND bus cycles.
// Depends on nfos_pkg.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid/in_ready, req_type, flash_address,     | to block
//           | write_byte, device_byte                         |
//   out     | out_valid/out_ready, bus_kind, bus_byte,        | from block
//           | op_failed, elapsed_ticks, last_of_run           |
//   cfg     | cfg_we, cfg_index, cfg_data                     | to block
//
// A request is decoded and the state updated in the cycle it is accepted;
// its results (up to 7) leave the burst register one per cycle while
// out_ready is high. A request holds the output until its last result
// is taken; the next request is taken in the cycle that result is taken.
// Ticks that give no result are taken every cycle the burst register is free.
// Reset: phase idle, counters zero, abort_ticks 0, fail_mask 1, reset cmd FFh.
`default_nettype none

module nand_flash_op_sequencer #(
    parameter int COLUMN_BITS     = 12,
    parameter int ROW_ADDR_CYCLES = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  req_type,
    input  wire logic [30:0] flash_address,
    input  wire logic [7:0]  write_byte,
    input  wire logic [7:0]  device_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       bus_kind,
    output logic [7:0]       bus_byte,
    output logic             op_failed,
    output logic [31:0]      elapsed_ticks,
    output logic             last_of_run,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import nfos_pkg::*;

    localparam int FULL_ADDR = 2 + ROW_ADDR_CYCLES;
    localparam logic [2:0] READ_N  = 3'(FULL_ADDR + 2);
    localparam logic [2:0] PROG_N  = 3'(FULL_ADDR + 1);
    localparam logic [2:0] ERASE_N = 3'(ROW_ADDR_CYCLES + 2);
    localparam logic [2:0] FULL_LAST = 3'(FULL_ADDR);
    localparam logic [2:0] ROW_LAST  = 3'(ROW_ADDR_CYCLES);
    localparam logic [7:0] HI_MASK = 8'((1 << (COLUMN_BITS - 8)) - 1);

    // config registers
    logic [31:0] abort_ticks_reg;
    logic [7:0]  fail_mask_reg;
    logic [7:0]  reset_command_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    op_kind_t    op_kind_reg, op_kind_next;
    logic [31:0] tick_count_reg, tick_count_next;
    logic        abort_sent_reg, abort_sent_next;

    // burst register
    logic        burst_valid_reg;
    burst_kind_t bkind_reg, bkind_next;
    logic [30:0] baddr_reg;
    logic [7:0]  bbyte_reg, bbyte_next;
    logic        bfailed_reg, bfailed_next;
    logic [31:0] bticks_reg;
    logic [2:0]  bcount_reg, bcount_next;
    logic [2:0]  bidx_reg;

    req_t        req;
    logic        start_ok;
    logic        in_fire;
    logic        out_fire;
    logic        last_out;
    logic [31:0] tick_inc;

    function automatic logic [7:0] addr_byte(input logic [30:0] a, input logic [2:0] j);
        logic [31:0] row;
        logic [2:0]  r;
        row = {1'b0, a} >> COLUMN_BITS;
        r   = j - 3'd2;
        if (j == 3'd0)
            return a[7:0];
        else if (j == 3'd1)
            return a[15:8] & HI_MASK;
        else
            return row[{r[1:0], 3'b000} +: 8];
    endfunction

    assign req      = req_t'(req_type);
    assign start_ok = (phase_reg == PH_IDLE) || (phase_reg == PH_OUT);
    assign last_out = (bidx_reg == bcount_reg - 3'd1);
    assign out_valid = burst_valid_reg;
    assign out_fire  = burst_valid_reg && out_ready;
    assign in_ready  = !burst_valid_reg || (out_ready && last_out);
    assign in_fire   = in_valid && in_ready;
    assign tick_inc  = (tick_count_reg == TICKS_MAX) ? tick_count_reg
                                                     : tick_count_reg + 32'd1;

    // next state and burst decode
    always_comb
    begin
        phase_next      = phase_reg;
        op_kind_next    = op_kind_reg;
        tick_count_next = tick_count_reg;
        abort_sent_next = abort_sent_reg;
        bkind_next      = BK_ERROR;
        bbyte_next      = 8'h00;
        bfailed_next    = 1'b0;
        bcount_next     = 3'd1;
        case (req)
            REQ_START_READ, REQ_START_PROG, REQ_START_ERASE:
            begin
                if (start_ok)
                begin
                    tick_count_next = 32'd0;
                    abort_sent_next = 1'b0;
                    case (req)
                        REQ_START_READ:
                        begin
                            phase_next   = PH_BUSY;
                            op_kind_next = OP_READ;
                            bkind_next   = BK_READ;
                            bcount_next  = READ_N;
                        end
                        REQ_START_PROG:
                        begin
                            phase_next   = PH_LOAD;
                            op_kind_next = OP_PROG;
                            bkind_next   = BK_PROG;
                            bcount_next  = PROG_N;
                        end
                        default:
                        begin
                            phase_next   = PH_BUSY;
                            op_kind_next = OP_ERASE;
                            bkind_next   = BK_ERASE;
                            bcount_next  = ERASE_N;
                        end
                    endcase
                end
            end
            REQ_DATA_BYTE:
            begin
                if (phase_reg == PH_LOAD)
                begin
                    bkind_next = BK_DATA;
                    bbyte_next = write_byte;
                end
            end
            REQ_CONFIRM:
            begin
                if (phase_reg == PH_LOAD)
                begin
                    bkind_next      = BK_CONFIRM;
                    phase_next      = PH_BUSY;
                    tick_count_next = 32'd0;
                    abort_sent_next = 1'b0;
                end
            end
            REQ_BUSY_DONE:
            begin
                if (phase_reg == PH_BUSY)
                begin
                    if (op_kind_reg == OP_READ)
                    begin
                        bkind_next = BK_DONE_READ;
                        phase_next = PH_OUT;
                    end
                    else
                    begin
                        bkind_next   = BK_DONE_STATUS;
                        bcount_next  = 3'd2;
                        bfailed_next = (device_byte & fail_mask_reg) == fail_mask_reg;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            REQ_READ_STROBE:
            begin
                if (phase_reg == PH_OUT)
                begin
                    bkind_next = BK_STROBE;
                    bbyte_next = device_byte;
                end
            end
            REQ_TICK:
            begin
                bcount_next = 3'd0;
                if (phase_reg == PH_BUSY)
                begin
                    tick_count_next = tick_inc;
                    if (op_kind_reg == OP_PROG && abort_ticks_reg != 32'd0 &&
                        !abort_sent_reg && tick_inc >= abort_ticks_reg)
                    begin
                        abort_sent_next = 1'b1;
                        bkind_next      = BK_ABORT;
                        bbyte_next      = reset_command_reg;
                        bcount_next     = 3'd1;
                    end
                end
            end
            default:
            begin
                bkind_next = BK_ERROR;
            end
        endcase
    end

    // result fields from the burst register
    always_comb
    begin
        bus_kind      = BUS_SEQ_ERROR;
        bus_byte      = 8'h00;
        op_failed     = 1'b0;
        elapsed_ticks = 32'd0;
        last_of_run   = last_out;
        case (bkind_reg)
            BK_READ, BK_PROG:
            begin
                if (bidx_reg == 3'd0)
                begin
                    bus_kind = BUS_COMMAND;
                    bus_byte = (bkind_reg == BK_READ) ? CMD_READ : CMD_PROGRAM;
                end
                else if (bidx_reg <= FULL_LAST)
                begin
                    bus_kind = BUS_ADDRESS;
                    bus_byte = addr_byte(baddr_reg, bidx_reg - 3'd1);
                end
                else
                begin
                    bus_kind = BUS_COMMAND;
                    bus_byte = CMD_READ_CONFIRM;
                end
            end
            BK_ERASE:
            begin
                if (bidx_reg == 3'd0)
                begin
                    bus_kind = BUS_COMMAND;
                    bus_byte = CMD_ERASE;
                end
                else if (bidx_reg <= ROW_LAST)
                begin
                    bus_kind = BUS_ADDRESS;
                    bus_byte = addr_byte(baddr_reg, bidx_reg + 3'd1);
                end
                else
                begin
                    bus_kind = BUS_COMMAND;
                    bus_byte = CMD_ERASE_CONFIRM;
                end
            end
            BK_DATA:
            begin
                bus_kind = BUS_WRITE_DATA;
                bus_byte = bbyte_reg;
            end
            BK_CONFIRM:
            begin
                bus_kind = BUS_COMMAND;
                bus_byte = CMD_PROG_CONFIRM;
            end
            BK_DONE_READ:
            begin
                bus_kind      = BUS_COMPLETION;
                elapsed_ticks = bticks_reg;
            end
            BK_DONE_STATUS:
            begin
                if (bidx_reg == 3'd0)
                begin
                    bus_kind = BUS_COMMAND;
                    bus_byte = CMD_STATUS_POLL;
                end
                else
                begin
                    bus_kind      = BUS_COMPLETION;
                    op_failed     = bfailed_reg;
                    elapsed_ticks = bticks_reg;
                end
            end
            BK_STROBE:
            begin
                bus_kind = BUS_READ_DATA;
                bus_byte = bbyte_reg;
            end
            BK_ABORT:
            begin
                bus_kind = BUS_COMMAND;
                bus_byte = bbyte_reg;
            end
            default:
            begin
                bus_kind = BUS_SEQ_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abort_ticks_reg   <= 32'd0;
            fail_mask_reg     <= 8'h01;
            reset_command_reg <= 8'hFF;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ABORT_TICKS:   abort_ticks_reg   <= cfg_data;
                CFG_FAIL_MASK:     fail_mask_reg     <= cfg_data[7:0];
                CFG_RESET_COMMAND: reset_command_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            op_kind_reg    <= OP_READ;
            tick_count_reg <= 32'd0;
            abort_sent_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            op_kind_reg    <= op_kind_next;
            tick_count_reg <= tick_count_next;
            abort_sent_reg <= abort_sent_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            bidx_reg        <= 3'd0;
            bcount_reg      <= 3'd1;
        end
        else if (in_fire && bcount_next != 3'd0)
        begin
            burst_valid_reg <= 1'b1;
            bidx_reg        <= 3'd0;
            bcount_reg      <= bcount_next;
        end
        else if (out_fire)
        begin
            if (last_out)
                burst_valid_reg <= 1'b0;
            else
                bidx_reg <= bidx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && bcount_next != 3'd0)
        begin
            bkind_reg   <= bkind_next;
            baddr_reg   <= flash_address;
            bbyte_reg   <= bbyte_next;
            bfailed_reg <= bfailed_next;
            bticks_reg  <= tick_count_reg;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> (bidx_reg < bcount_reg))
        else $error("burst index beyond burst length");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!burst_valid_reg || (out_ready && last_out)))
        else $error("request accepted over a pending burst");

    a_abort_prog: assert property (@(posedge clk) disable iff (!rst_n)
        abort_sent_reg |-> (op_kind_reg == OP_PROG))
        else $error("abort flagged outside a program operation");

    a_load_prog: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOAD) |-> (op_kind_reg == OP_PROG))
        else $error("data load phase without program operation");

endmodule

`default_nettype wire
